/* hw/rtl/rtcc_pkg.sv */
// Package for the calendar clock: word types, command codes and calendar helpers.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rtcc_pkg;

   localparam int unsigned CmdWidth   = 2;
   localparam int unsigned InWidth    = 7;
   localparam int unsigned YearWidth  = 14;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned DayWidth   = 5;
   localparam int unsigned HourWidth  = 5;
   localparam int unsigned MinWidth   = 6;

   localparam logic [YearWidth-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [MonthWidth-1:0] MONTH_MAX  = 4'd12;
   localparam logic [HourWidth-1:0]  HOUR_NOON  = 5'd12;
   localparam logic [HourWidth-1:0]  HOUR_LAST  = 5'd23;
   localparam logic [MinWidth-1:0]   MIN_LAST   = 6'd59;

   // Divisibility by 25 through the modular inverse: 25 * 7209 == 1 (mod 2^14),
   // so y is a multiple of 25 exactly when y * 7209 mod 2^14 <= (2^14-1)/25.
   localparam logic [YearWidth-1:0]  INV25      = 14'd7209;
   localparam logic [YearWidth-1:0]  DIV25_MAX  = 14'd655;

   localparam logic [DayWidth-1:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };
   localparam logic [DayWidth-1:0] FEB_LEAP_LEN = 5'd29;
   localparam logic [DayWidth-1:0] LONG_MONTH   = 5'd31;

   typedef enum logic [CmdWidth-1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_DATE = 2'd1,
      CMD_SET_TIME = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [CmdWidth-1:0]  cmd;
      logic [InWidth-1:0]   new_month;
      logic [InWidth-1:0]   new_day;
      logic [YearWidth-1:0] new_year;
      logic [InWidth-1:0]   new_hour;
      logic [InWidth-1:0]   new_minute;
      logic [InWidth-1:0]   new_second;
   } req_word_type;

   typedef struct packed {
      logic [MonthWidth-1:0] cur_month;
      logic [DayWidth-1:0]   cur_day;
      logic [YearWidth-1:0]  cur_year;
      logic [HourWidth-1:0]  cur_hour;
      logic [MinWidth-1:0]   cur_minute;
      logic [MinWidth-1:0]   cur_second;
      logic [HourWidth-1:0]  shown_hour;
      logic                  is_pm;
      logic                  set_rejected;
   } rsp_word_type;

   typedef struct packed {
      logic [MonthWidth-1:0] month;
      logic [DayWidth-1:0]   day;
      logic [YearWidth-1:0]  year;
      logic [HourWidth-1:0]  hour;
      logic [MinWidth-1:0]   minute;
      logic [MinWidth-1:0]   second;
   } cal_type;

   localparam cal_type CAL_RESET = '{
      month:  4'd4,
      day:    5'd30,
      year:   14'd2025,
      hour:   5'd12,
      minute: 6'd0,
      second: 6'd0
   };

   function automatic logic is_leap(input logic [YearWidth-1:0] y);
      logic [2*YearWidth-1:0] prod;
      logic                   div25;
      prod  = y * {{YearWidth{1'b0}}, INV25};
      div25 = (prod[YearWidth-1:0] <= DIV25_MAX);
      // multiple of 4 but not of 100, or multiple of 400
      return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
   endfunction

   function automatic logic [DayWidth-1:0] days_in_month(input logic [InWidth-1:0] m,
                                                          input logic [YearWidth-1:0] y);
      logic [MonthWidth-1:0] idx;
      idx = m[MonthWidth-1:0] - 4'd1;
      if (m < 7'd1 || m > 7'd12) begin
         return LONG_MONTH;
      end else if (m == 7'd2 && is_leap(y)) begin
         return FEB_LEAP_LEN;
      end else begin
         return MONTH_LEN[idx];
      end
   endfunction

endpackage

/* hw/rtl/rtcc_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on rtcc_pkg.
`timescale 1ns / 1ps

interface rtcc_req_if;
   import rtcc_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source(output valid, output word, input ready);
   modport sink(input valid, input word, output ready);
endinterface

interface rtcc_rsp_if;
   import rtcc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source(output valid, output word, input ready);
   modport sink(input valid, input word, output ready);
endinterface

/* hw/rtl/rtcc_next.sv */
// Next-value logic of the calendar: tick carry chain, validated loads, display hour.
// Depends on rtcc_pkg.
`timescale 1ns / 1ps

module rtcc_next (
   input  rtcc_pkg::cal_type      cal,
   input  rtcc_pkg::req_word_type word,
   input  logic                   hour24_mode,
   output rtcc_pkg::cal_type      cal_next,
   output rtcc_pkg::rsp_word_type rsp
);
   import rtcc_pkg::*;

   logic                 date_ok;
   logic                 time_ok;
   logic                 rejected;
   logic [HourWidth-1:0] half_hour;

   assign date_ok = (word.new_year <= YEAR_MAX) &&
                    (word.new_month >= 7'd1) && (word.new_month <= 7'd12) &&
                    (word.new_day >= 7'd1) &&
                    (word.new_day <= {2'b00, days_in_month(word.new_month, word.new_year)});

   assign time_ok = (word.new_hour < 7'd24) && (word.new_minute < 7'd60) &&
                    (word.new_second < 7'd60);

   always_comb begin
      cal_next = cal;
      rejected = 1'b0;
      case (word.cmd)
         CMD_TICK: begin
            if (cal.second != MIN_LAST) begin
               cal_next.second = cal.second + 6'd1;
            end else begin
               cal_next.second = '0;
               if (cal.minute != MIN_LAST) begin
                  cal_next.minute = cal.minute + 6'd1;
               end else begin
                  cal_next.minute = '0;
                  if (cal.hour < HOUR_LAST) begin
                     cal_next.hour = cal.hour + 5'd1;
                  end else begin
                     cal_next.hour = '0;
                     if (cal.day < days_in_month({3'b000, cal.month}, cal.year)) begin
                        cal_next.day = cal.day + 5'd1;
                     end else begin
                        cal_next.day = 5'd1;
                        if (cal.month < MONTH_MAX) begin
                           cal_next.month = cal.month + 4'd1;
                        end else begin
                           cal_next.month = 4'd1;
                           cal_next.year  = (cal.year >= YEAR_MAX) ? '0 : cal.year + 14'd1;
                        end
                     end
                  end
               end
            end
         end
         CMD_SET_DATE: begin
            if (date_ok) begin
               cal_next.month = word.new_month[MonthWidth-1:0];
               cal_next.day   = word.new_day[DayWidth-1:0];
               cal_next.year  = word.new_year;
            end else begin
               rejected = 1'b1;
            end
         end
         CMD_SET_TIME: begin
            if (time_ok) begin
               cal_next.hour   = word.new_hour[HourWidth-1:0];
               cal_next.minute = word.new_minute[MinWidth-1:0];
               cal_next.second = word.new_second[MinWidth-1:0];
            end else begin
               rejected = 1'b1;
            end
         end
         default: begin
            // unused code: hold everything
         end
      endcase
   end

   // 12-hour display: fold the afternoon and show midnight/noon as 12
   assign half_hour = (cal_next.hour >= HOUR_NOON) ? cal_next.hour - HOUR_NOON : cal_next.hour;

   always_comb begin
      rsp.cur_month    = cal_next.month;
      rsp.cur_day      = cal_next.day;
      rsp.cur_year     = cal_next.year;
      rsp.cur_hour     = cal_next.hour;
      rsp.cur_minute   = cal_next.minute;
      rsp.cur_second   = cal_next.second;
      rsp.is_pm        = (cal_next.hour >= HOUR_NOON);
      rsp.set_rejected = rejected;
      if (hour24_mode) begin
         rsp.shown_hour = cal_next.hour;
      end else if (half_hour == '0) begin
         rsp.shown_hour = HOUR_NOON;
      end else begin
         rsp.shown_hour = half_hour;
      end
   end

endmodule

/* hw/rtl/calendar_clock_with_validated_set.sv */
// Top level of the calendar clock: input register, calendar state, result register.
// Depends on rtcc_pkg, rtcc_if (rtcc_req_if, rtcc_rsp_if) and rtcc_next.
`timescale 1ns / 1ps

// Calendar clock with validated set. Each request word is a one-second tick, a
// set-date or a set-time command; each one returns exactly one response word with
// the full date and time after the command, the hour as displayed (0-23, or 1-12
// with a PM flag when csr hour24_mode is 0) and a flag that marks a rejected set.
// A set whose fields fail the checks (month 1-12, day within the month length with
// Gregorian leap years, year up to 9999, hour/minute/second within 24/60/60)
// changes nothing, and so does the unused command code. Reset state is 12:00:00 on
// April 30, 2025, 24-hour mode. Throughput is one word per clock while the response
// side takes words; each word passes the input register, then the single-pass
// calendar update into the result register, which holds the response word until
// it is taken. The carry chain and validation sit in one combinational pass between
// those two registers. Write hour24_mode only while no word is in flight.
module calendar_clock_with_validated_set (
   input  logic        clock,
   input  logic        reset,
   rtcc_req_if.sink    req_chan,
   rtcc_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import rtcc_pkg::*;

   logic         hour24_ff;
   cal_type      cal_ff;
   cal_type      cal_in;
   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         out_valid_ff;
   rsp_word_type out_word_ff;
   rsp_word_type out_word_in;
   logic         advance;
   logic         take_req;

   // advance the held word when the result register is free or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take_req = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.word  = out_word_ff;

   rtcc_next u_next (
      .cal         (cal_ff),
      .word        (in_word_ff),
      .hour24_mode (hour24_ff),
      .cal_next    (cal_in),
      .rsp         (out_word_in)
   );

   // display mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         hour24_ff <= 1'b1;
      end else if (csr_wr_en) begin
         hour24_ff <= csr_wr_data;
      end
   end

   // calendar state: commit only when the word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= CAL_RESET;
      end else if (advance) begin
         cal_ff <= cal_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_word_ff <= req_chan.word;
      end
   end

   // result register: hold until taken, refill on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

endmodule

/* tb/sv/tb.sv */
// Testbench for calendar_clock_with_validated_set: directed table, then random words.
// Depends on rtcc_pkg, rtcc_if and the calendar clock RTL; checks against its own predictor.
`timescale 1ns / 1ps

module tb;
   import rtcc_pkg::*;

   // cmd value with no name in the package; the block must ignore it
   localparam logic [CmdWidth-1:0] CmdUnused = 2'd3;

   localparam int unsigned ClockHalf   = 6;
   localparam int unsigned ResetCycles = 7;
   localparam int unsigned StallLimit  = 2000;   // cycles with no word moving on either side
   localparam int unsigned PhaseWords  = 140;
   localparam int unsigned PhaseCount  = 6;
   localparam int unsigned DrainCycles = 8;      // two-stage pipe, plus margin

   typedef struct {
      req_word_type req;
      bit           checked;   // expected word typed in by hand
      rsp_word_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic csr_wr_data;

   rtcc_req_if req_if ();
   rtcc_rsp_if rsp_if ();

   calendar_clock_with_validated_set dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(ClockHalf) clock = ~clock;

   // Predictor copy of the calendar and the display mode.
   int unsigned cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year;
   bit          hour24;

   rsp_word_type expected_words [$];
   int unsigned  fail_count = 0;
   int unsigned  quiet_cycles = 0;

   // Hand-typed expectation that rides along with the word being offered.
   logic         row_checked;
   rsp_word_type row_rsp;

   // Pacing state of the two sides.
   bit          tx_calm = 1'b0;
   int unsigned tx_calm_left = 0;
   bit          rx_calm = 1'b0;
   int unsigned rx_calm_left = 0;
   int unsigned rx_hold = 0;

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 31;
      endcase
   endfunction

   // Apply one word to the predictor calendar and return the word the block
   // should answer with.
   function automatic rsp_word_type clock_next(input req_word_type w);
      rsp_word_type r;
      bit           rejected;
      int unsigned  shown;
      rejected = 1'b0;
      case (w.cmd)
         CMD_TICK: begin
            // carry runs second -> minute -> hour -> day -> month -> year
            cal_sec = cal_sec + 1;
            if (cal_sec >= 60) begin
               cal_sec = 0;
               cal_min = cal_min + 1;
               if (cal_min >= 60) begin
                  cal_min  = 0;
                  cal_hour = cal_hour + 1;
                  if (cal_hour >= 24) begin
                     cal_hour = 0;
                     cal_day  = cal_day + 1;
                     if (cal_day > days_in(cal_month, cal_year)) begin
                        cal_day   = 1;
                        cal_month = cal_month + 1;
                        if (cal_month > 12) begin
                           cal_month = 1;
                           cal_year  = (cal_year >= 9999) ? 0 : cal_year + 1;
                        end
                     end
                  end
               end
            end
         end
         CMD_SET_DATE: begin
            if (w.new_year <= 9999 && w.new_month >= 1 && w.new_month <= 12 &&
                w.new_day >= 1 && w.new_day <= days_in(w.new_month, w.new_year)) begin
               cal_month = w.new_month;
               cal_day   = w.new_day;
               cal_year  = w.new_year;
            end else begin
               rejected = 1'b1;
            end
         end
         CMD_SET_TIME: begin
            if (w.new_hour < 24 && w.new_minute < 60 && w.new_second < 60) begin
               cal_hour = w.new_hour;
               cal_min  = w.new_minute;
               cal_sec  = w.new_second;
            end else begin
               rejected = 1'b1;
            end
         end
         default: ;   // unused command: hold everything, no flag
      endcase

      if (hour24) begin
         shown = cal_hour;
      end else begin
         shown = (cal_hour % 12 == 0) ? 12 : cal_hour % 12;
      end

      r.cur_month    = MonthWidth'(cal_month);
      r.cur_day      = DayWidth'(cal_day);
      r.cur_year     = YearWidth'(cal_year);
      r.cur_hour     = HourWidth'(cal_hour);
      r.cur_minute   = MinWidth'(cal_min);
      r.cur_second   = MinWidth'(cal_sec);
      r.shown_hour   = HourWidth'(shown);
      r.is_pm        = (cal_hour >= 12);
      r.set_rejected = rejected;
      return r;
   endfunction

   function automatic req_word_type make_req(input logic [CmdWidth-1:0] cmd,
                                             input int unsigned m, input int unsigned d,
                                             input int unsigned y, input int unsigned h,
                                             input int unsigned mi, input int unsigned s);
      req_word_type q;
      q.cmd        = cmd;
      q.new_month  = InWidth'(m);
      q.new_day    = InWidth'(d);
      q.new_year   = YearWidth'(y);
      q.new_hour   = InWidth'(h);
      q.new_minute = InWidth'(mi);
      q.new_second = InWidth'(s);
      return q;
   endfunction

   function automatic rsp_word_type make_rsp(input int unsigned m, input int unsigned d,
                                             input int unsigned y, input int unsigned h,
                                             input int unsigned mi, input int unsigned s,
                                             input int unsigned shown, input bit pm,
                                             input bit rejected);
      rsp_word_type p;
      p.cur_month    = MonthWidth'(m);
      p.cur_day      = DayWidth'(d);
      p.cur_year     = YearWidth'(y);
      p.cur_hour     = HourWidth'(h);
      p.cur_minute   = MinWidth'(mi);
      p.cur_second   = MinWidth'(s);
      p.shown_hour   = HourWidth'(shown);
      p.is_pm        = pm;
      p.set_rejected = rejected;
      return p;
   endfunction

   function automatic dir_row_type row(input req_word_type q, input bit checked,
                                       input rsp_word_type p);
      dir_row_type t;
      t.req     = q;
      t.checked = checked;
      t.rsp     = p;
      return t;
   endfunction

   function automatic string word_text(input rsp_word_type p);
      return $sformatf("%0d/%0d/%0d %0d:%0d:%0d shown=%0d pm=%0d rej=%0d",
                       p.cur_month, p.cur_day, p.cur_year, p.cur_hour, p.cur_minute,
                       p.cur_second, p.shown_hour, p.is_pm, p.set_rejected);
   endfunction

   // Idle length for either side: mostly none, some short, a few long.
   function automatic int unsigned idle_len(input bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one word after a random gap and hold it until the block takes it.
   task automatic send_word(input req_word_type w, input bit checked, input rsp_word_type want);
      int unsigned gap;
      gap = idle_len(tx_calm);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.word  <= w;
      row_checked  <= checked;
      row_rsp      <= want;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drain the pipe, then write the display mode while nothing is in flight.
   task automatic write_hour_mode(input bit mode);
      req_if.valid <= 1'b0;
      // let the scoreboard log the last accepted word before looking at the queue
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Result side: stall at random, with calm stretches where ready stays high.
   always @(posedge clock) begin : rsp_pace
      int unsigned n;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_hold = 0;
      end else if (rx_hold != 0) begin
         rsp_if.ready <= 1'b0;
         rx_hold = rx_hold - 1;
      end else begin
         if (rx_calm_left == 0) begin
            rx_calm      = ($urandom_range(0, 3) == 0);
            rx_calm_left = $urandom_range(10, 150);
         end
         rx_calm_left = rx_calm_left - 1;
         n = idle_len(rx_calm);
         rsp_if.ready <= (n == 0);
         if (n != 0) rx_hold = n - 1;
      end
   end

   // Scoreboard: predict on every accepted request word, then check every
   // accepted response word against the oldest expectation. Both sides are
   // handled in one process so push and pop never race.
   always @(posedge clock) begin : score
      rsp_word_type want;
      rsp_word_type got;
      bit           moved;
      moved = 1'b0;
      if (reset) begin
         cal_sec   = CAL_RESET.second;
         cal_min   = CAL_RESET.minute;
         cal_hour  = CAL_RESET.hour;
         cal_day   = CAL_RESET.day;
         cal_month = CAL_RESET.month;
         cal_year  = CAL_RESET.year;
         hour24    = 1'b1;
      end else begin
         if (csr_wr_en) hour24 = csr_wr_data;
         if (req_if.valid && req_if.ready) begin
            moved = 1'b1;
            want  = clock_next(req_if.word);
            // a hand-typed row overrides the predictor, which still advances
            if (row_checked) want = row_rsp;
            expected_words.push_back(want);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            got   = rsp_if.word;
            if (expected_words.size() == 0) begin
               if (fail_count < 10) $display("unexpected word: %s", word_text(got));
               fail_count = fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got.cur_month !== want.cur_month || got.cur_day !== want.cur_day ||
                   got.cur_year !== want.cur_year || got.cur_hour !== want.cur_hour ||
                   got.cur_minute !== want.cur_minute || got.cur_second !== want.cur_second ||
                   got.shown_hour !== want.shown_hour || got.is_pm !== want.is_pm ||
                   got.set_rejected !== want.set_rejected) begin
                  if (fail_count < 10) begin
                     $display("mismatch: expected %s, got %s", word_text(want), word_text(got));
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
   end

   // Stop a hung run.
   initial begin : watchdog
      wait (quiet_cycles >= StallLimit);
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      dir_row_type  dir_table [$];
      rsp_word_type stuck;
      req_word_type w;
      int unsigned  p, k, pick, m, d, y, h, mi, s;

      req_if.valid <= 1'b0;
      req_if.word  <= '0;
      row_checked  <= 1'b0;
      row_rsp      <= '0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= 1'b0;

      // Directed table, 24-hour mode from reset. Typed rows are read straight
      // off the calendar rules; the rest go through the predictor.
      dir_table.push_back(row(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_rsp(4, 30, 2025, 12, 0, 1, 12, 1'b1, 1'b0)));
      // unused command with every field at its maximum
      dir_table.push_back(row(make_req(CmdUnused, 127, 127, 16383, 127, 127, 127), 1'b1,
                              make_rsp(4, 30, 2025, 12, 0, 1, 12, 1'b1, 1'b0)));
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 23, 59, 59), 1'b1,
                              make_rsp(4, 30, 2025, 23, 59, 59, 23, 1'b1, 1'b0)));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 12, 31, 9999, 0, 0, 0), 1'b1,
                              make_rsp(12, 31, 9999, 23, 59, 59, 23, 1'b1, 1'b0)));
      // year wraps to zero
      dir_table.push_back(row(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b1,
                              make_rsp(1, 1, 0, 0, 0, 0, 0, 1'b0, 1'b0)));
      // year zero is a leap year
      dir_table.push_back(row(make_req(CMD_SET_DATE, 2, 29, 0, 0, 0, 0), 1'b1,
                              make_rsp(2, 29, 0, 0, 0, 0, 0, 1'b0, 1'b0)));
      // every rejected set below leaves the calendar where it is
      stuck = make_rsp(2, 29, 0, 0, 0, 0, 0, 1'b0, 1'b1);
      dir_table.push_back(row(make_req(CMD_SET_DATE, 2, 29, 1900, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 2, 29, 2023, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 0, 1, 2000, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 13, 1, 2000, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 127, 127, 16383, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 1, 0, 2000, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 1, 1, 10000, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 4, 31, 2024, 0, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 24, 0, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 0, 60, 0), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 0, 0, 60), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 127, 127, 127), 1'b1, stuck));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 2, 29, 2000, 0, 0, 0), 1'b1,
                              make_rsp(2, 29, 2000, 0, 0, 0, 0, 1'b0, 1'b0)));
      // leap and common February rollovers
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 23, 59, 59), 1'b0, '0));
      dir_table.push_back(row(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 2, 28, 2023, 0, 0, 0), 1'b0, '0));
      dir_table.push_back(row(make_req(CMD_SET_TIME, 0, 0, 0, 23, 59, 59), 1'b0, '0));
      dir_table.push_back(row(make_req(CMD_TICK, 0, 0, 0, 0, 0, 0), 1'b0, '0));
      dir_table.push_back(row(make_req(CMD_SET_DATE, 12, 31, 2023, 0, 0, 0), 1'b0, '0));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         send_word(dir_table[i].req, dir_table[i].checked, dir_table[i].rsp);
      end

      // Random phases, alternating the display mode; each write drains the pipe.
      for (p = 0; p < PhaseCount; p++) begin
         write_hour_mode(p[0] ? 1'b1 : 1'b0);
         for (k = 0; k < PhaseWords; k++) begin
            if (tx_calm_left == 0) begin
               tx_calm      = ($urandom_range(0, 3) == 0);
               tx_calm_left = $urandom_range(10, 120);
            end
            tx_calm_left = tx_calm_left - 1;

            // noise in the fields a command ignores toggles every input bit
            w = make_req(CMD_TICK, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 16383), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 127));
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
               w.cmd = CMD_TICK;
            end else if (pick < 63) begin
               // well-formed set time, often just before a carry
               w.cmd = CMD_SET_TIME;
               h  = $urandom_range(0, 23);
               mi = $urandom_range(0, 59);
               s  = $urandom_range(0, 59);
               case ($urandom_range(0, 3))
                  0: ;
                  1: begin h = 23; mi = 59; s = $urandom_range(50, 59); end
                  2: begin h = 11; mi = 59; s = $urandom_range(50, 59); end
                  default: begin mi = 59; s = $urandom_range(55, 59); end
               endcase
               w.new_hour   = InWidth'(h);
               w.new_minute = InWidth'(mi);
               w.new_second = InWidth'(s);
            end else if (pick < 77) begin
               // well-formed set date, often on the last day of a month
               w.cmd = CMD_SET_DATE;
               case ($urandom_range(0, 9))
                  0: y = 0;
                  1: y = 100;
                  2: y = 400;
                  3: y = 1900;
                  4: y = 2000;
                  5: y = 2024;
                  6: y = 9999;
                  7: y = 4 * $urandom_range(0, 2499);
                  default: y = $urandom_range(0, 9999);
               endcase
               m = $urandom_range(1, 12);
               if ($urandom_range(0, 1) == 0) d = days_in(m, y);
               else d = $urandom_range(1, days_in(m, y));
               w.new_month = InWidth'(m);
               w.new_day   = InWidth'(d);
               w.new_year  = YearWidth'(y);
            end else if (pick < 86) begin
               // broken set date: exactly one field out of range
               w.cmd = CMD_SET_DATE;
               y = $urandom_range(0, 9999);
               m = $urandom_range(1, 12);
               d = $urandom_range(1, days_in(m, y));
               case ($urandom_range(0, 4))
                  0: m = 0;
                  1: m = $urandom_range(13, 127);
                  2: d = 0;
                  3: d = $urandom_range(days_in(m, y) + 1, 127);
                  default: y = $urandom_range(10000, 16383);
               endcase
               w.new_month = InWidth'(m);
               w.new_day   = InWidth'(d);
               w.new_year  = YearWidth'(y);
            end else if (pick < 94) begin
               // broken set time: one field or all of them out of range
               w.cmd = CMD_SET_TIME;
               h  = $urandom_range(0, 23);
               mi = $urandom_range(0, 59);
               s  = $urandom_range(0, 59);
               case ($urandom_range(0, 3))
                  0: h  = $urandom_range(24, 127);
                  1: mi = $urandom_range(60, 127);
                  2: s  = $urandom_range(60, 127);
                  default: begin
                     h  = $urandom_range(24, 127);
                     mi = $urandom_range(60, 127);
                     s  = $urandom_range(60, 127);
                  end
               endcase
               w.new_hour   = InWidth'(h);
               w.new_minute = InWidth'(mi);
               w.new_second = InWidth'(s);
            end else begin
               // raw noise, the unused command among it
               w.cmd = CmdWidth'($urandom_range(0, 3));
            end
            send_word(w, 1'b0, '0);
         end
      end

      // Drop valid, wait out every expected word, then let the pipe settle.
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
